[hdl/mpdfa_pkg.sv]
// ---------------------------------------------------------------------------
// mpdfa_pkg
// Shared types, byte codes and helpers for the multi-pattern dfa matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package mpdfa_pkg;

	// field widths
	localparam int BYTE_W = 8;
	localparam int NODE_W = 10;
	localparam int CNT_W  = 11;

	// default automaton size
	localparam int NODES_DEF = 1024;

	// operation codes
	typedef enum logic [1:0] {
		OP_SCAN   = 2'd0,
		OP_TRANS  = 2'd1,
		OP_ACCEPT = 2'd2
	} op_t;

	// zero-width sequence bytes
	localparam logic [BYTE_W-1:0] B_E2 = 8'hE2;
	localparam logic [BYTE_W-1:0] B_80 = 8'h80;
	localparam logic [BYTE_W-1:0] B_8B = 8'h8B;
	localparam logic [BYTE_W-1:0] B_8E = 8'h8E;
	localparam logic [BYTE_W-1:0] B_81 = 8'h81;
	localparam logic [BYTE_W-1:0] B_A0 = 8'hA0;
	localparam logic [BYTE_W-1:0] B_EF = 8'hEF;
	localparam logic [BYTE_W-1:0] B_BB = 8'hBB;
	localparam logic [BYTE_W-1:0] B_BF = 8'hBF;

	// whitespace bytes
	localparam logic [BYTE_W-1:0] B_TAB = 8'h09;
	localparam logic [BYTE_W-1:0] B_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] B_SPC = 8'h20;

	// pending byte counts
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TRN  = 4'b0010,
		ST_ACC  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] x);
		return (x == B_SPC) || (x >= B_TAB && x <= B_CR);
	endfunction

	function automatic logic is_lead(input logic [BYTE_W-1:0] x);
		return (x == B_E2) || (x == B_EF);
	endfunction

endpackage

`default_nettype wire

[hdl/multi_pattern_dfa_matcher.sv]
// ---------------------------------------------------------------------------
// multi_pattern_dfa_matcher
// Aho-Corasick scanner over a software-loaded full transition table.
// ---------------------------------------------------------------------------
// A scan beat is taken while the block is idle, then the block walks the
// automaton one step at a time, each step passing ST_TRN and ST_ACC: the
// transition memory read, then the accept-flag memory read of the node it
// lands on. A byte causes zero to three steps (whitespace and dropped
// zero-width sequences cost none, a broken sequence or the end-of-message
// flush releases up to three), and a last byte adds a result beat; a
// transition or accept-flag write leaves the block idle. Only one beat
// is in flight: in_stall is high from the accepted beat until its steps
// finish and, on a last byte, until the matched beat is taken from the
// output register. Both tables power up undefined and must be loaded
// before use; there is no clearing pass.
// node_count must only be written while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_pattern_dfa_matcher #(
	parameter int NODES = mpdfa_pkg::NODES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_we,
	input  wire logic [mpdfa_pkg::CNT_W-1:0]  cfg_data,
	// input beats
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  operation,
	input  wire logic [mpdfa_pkg::BYTE_W-1:0] data_byte,
	input  wire logic                        last_byte,
	input  wire logic [mpdfa_pkg::NODE_W-1:0] node_index,
	input  wire logic [mpdfa_pkg::NODE_W-1:0] target_node,
	input  wire logic                        accept_value,
	// result beats
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             matched
);

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int BW = mpdfa_pkg::BYTE_W;
	localparam int AW = NW + BW;

	// tables
	logic [mpdfa_pkg::NODE_W-1:0] trans_mem [NODES*256];
	logic                         acc_mem   [NODES];

	mpdfa_pkg::state_t state_q;

	logic [mpdfa_pkg::CNT_W-1:0]  node_count_q;
	logic [mpdfa_pkg::NODE_W-1:0] cur_q;
	logic                         found_q;
	logic [1:0]                   pend_cnt_q;
	logic [BW-1:0]                pend0_q;
	logic [BW-1:0]                pend1_q;
	logic                         last_q;
	logic                         matched_q;

	// bytes waiting to step the automaton
	logic [BW-1:0]                step_q [3];
	logic [1:0]                   step_cnt_q;

	// memory read stage
	logic [mpdfa_pkg::NODE_W-1:0] trans_rd_s1;
	logic                         s_oob_s1;
	logic                         acc_rd_s1;
	logic                         acc_ok_s1;

	logic                         in_acc;
	logic                         is_scan;

	// byte list built for an accepted scan beat
	logic [BW-1:0]                lst [3];
	logic [1:0]                   lst_n;
	logic [1:0]                   new_pc;
	logic [BW-1:0]                new_p0;
	logic [BW-1:0]                new_p1;
	logic                         fresh;
	logic                         seq_cont;
	logic                         seq_zw;

	logic [BW-1:0]                rd_byte;
	logic [mpdfa_pkg::NODE_W-1:0] s_eff;
	logic                         s_oob;
	logic [AW-1:0]                rd_addr;
	logic [mpdfa_pkg::NODE_W-1:0] nxt_raw;
	logic [mpdfa_pkg::NODE_W-1:0] nxt_eff;
	logic                         found_new;
	logic                         nc_zero;

	assign in_stall  = (state_q != mpdfa_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign is_scan   = (operation == mpdfa_pkg::OP_SCAN);
	assign out_valid = (state_q == mpdfa_pkg::ST_OUT);
	assign matched   = matched_q;
	assign nc_zero   = (node_count_q == '0);

	// sequence detection against the pending bytes
	assign seq_cont = (pend0_q == mpdfa_pkg::B_E2 &&
			(data_byte == mpdfa_pkg::B_80 || data_byte == mpdfa_pkg::B_81)) ||
		(pend0_q == mpdfa_pkg::B_EF && data_byte == mpdfa_pkg::B_BB);
	assign seq_zw = (pend0_q == mpdfa_pkg::B_E2 && pend1_q == mpdfa_pkg::B_80 &&
			data_byte >= mpdfa_pkg::B_8B && data_byte <= mpdfa_pkg::B_8E) ||
		(pend0_q == mpdfa_pkg::B_E2 && pend1_q == mpdfa_pkg::B_81 &&
			data_byte == mpdfa_pkg::B_A0) ||
		(pend0_q == mpdfa_pkg::B_EF && pend1_q == mpdfa_pkg::B_BB &&
			data_byte == mpdfa_pkg::B_BF);

	// steps released by this byte, in automaton order
	always_comb begin
		lst[0] = '0;
		lst[1] = '0;
		lst[2] = '0;
		lst_n  = 2'd0;
		new_pc = pend_cnt_q;
		new_p0 = pend0_q;
		new_p1 = pend1_q;
		fresh  = 1'b0;
		case (pend_cnt_q)
			mpdfa_pkg::PEND_NONE: begin
				fresh = 1'b1;
			end
			mpdfa_pkg::PEND_ONE: begin
				if (seq_cont) begin
					new_pc = mpdfa_pkg::PEND_TWO;
					new_p1 = data_byte;
				end else begin
					// broken after the lead byte
					lst[0] = pend0_q;
					lst_n  = 2'd1;
					fresh  = 1'b1;
				end
			end
			mpdfa_pkg::PEND_TWO: begin
				if (seq_zw) begin
					new_pc = mpdfa_pkg::PEND_NONE;
				end else begin
					lst[0] = pend0_q;
					lst[1] = pend1_q;
					lst_n  = 2'd2;
					fresh  = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		// byte examined again with nothing pending
		if (fresh) begin
			new_pc = mpdfa_pkg::PEND_NONE;
			if (mpdfa_pkg::is_blank(data_byte)) begin
				new_pc = mpdfa_pkg::PEND_NONE;
			end else if (mpdfa_pkg::is_lead(data_byte)) begin
				new_pc = mpdfa_pkg::PEND_ONE;
				new_p0 = data_byte;
			end else begin
				lst[lst_n] = data_byte;
				lst_n      = lst_n + 2'd1;
			end
		end
		// end of message flushes what is still pending
		if (last_byte) begin
			if (new_pc != mpdfa_pkg::PEND_NONE && lst_n != 2'd3) begin
				lst[lst_n] = new_p0;
				lst_n      = lst_n + 2'd1;
			end
			if (new_pc == mpdfa_pkg::PEND_TWO && lst_n != 2'd3) begin
				lst[lst_n] = new_p1;
				lst_n      = lst_n + 2'd1;
			end
			new_pc = mpdfa_pkg::PEND_NONE;
		end
	end

	// transition read address: current node with out-of-range fallback
	assign rd_byte = (state_q == mpdfa_pkg::ST_IDLE) ? lst[0] : step_q[1];
	assign s_eff   = ({1'b0, cur_q} >= node_count_q) ? '0 : cur_q;
	assign s_oob   = !(32'(s_eff) < NODES);
	assign rd_addr = {NW'(s_eff), rd_byte};

	// landing node from the transition read; not ready always lands on the root
	assign nxt_raw   = s_oob_s1 ? '0 : trans_rd_s1;
	assign nxt_eff   = (nc_zero || ({1'b0, nxt_raw} >= node_count_q)) ? '0 : nxt_raw;
	assign found_new = found_q | (acc_ok_s1 & acc_rd_s1);

	// table memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (in_acc && operation == mpdfa_pkg::OP_TRANS && 32'(node_index) < NODES) begin
			trans_mem[{NW'(node_index), data_byte}] <= target_node;
		end
		trans_rd_s1 <= trans_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_acc && operation == mpdfa_pkg::OP_ACCEPT && 32'(node_index) < NODES) begin
			acc_mem[NW'(node_index)] <= accept_value;
		end
		acc_rd_s1 <= acc_mem[NW'(nxt_eff)];
	end

	// payload registers
	always_ff @(posedge clk) begin
		s_oob_s1 <= s_oob;
		if (in_acc && is_scan) begin
			step_q[0] <= lst[0];
			step_q[1] <= lst[1];
			step_q[2] <= lst[2];
			pend0_q   <= new_p0;
			pend1_q   <= new_p1;
		end else if (state_q == mpdfa_pkg::ST_ACC) begin
			step_q[0] <= step_q[1];
			step_q[1] <= step_q[2];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mpdfa_pkg::ST_IDLE;
			node_count_q <= '0;
			cur_q        <= '0;
			found_q      <= 1'b0;
			pend_cnt_q   <= mpdfa_pkg::PEND_NONE;
			step_cnt_q   <= 2'd0;
			last_q       <= 1'b0;
			matched_q    <= 1'b0;
			acc_ok_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_data;
			end
			case (state_q)
				mpdfa_pkg::ST_IDLE: begin
					if (in_acc && is_scan) begin
						pend_cnt_q <= new_pc;
						step_cnt_q <= lst_n;
						last_q     <= last_byte;
						if (lst_n != 2'd0) begin
							state_q <= mpdfa_pkg::ST_TRN;
						end else if (last_byte) begin
							matched_q <= !nc_zero && found_q;
							cur_q     <= '0;
							found_q   <= 1'b0;
							state_q   <= mpdfa_pkg::ST_OUT;
						end
					end
				end
				mpdfa_pkg::ST_TRN: begin
					cur_q     <= nxt_eff;
					acc_ok_s1 <= !nc_zero && (32'(nxt_eff) < NODES);
					state_q   <= mpdfa_pkg::ST_ACC;
				end
				mpdfa_pkg::ST_ACC: begin
					step_cnt_q <= step_cnt_q - 2'd1;
					if (step_cnt_q > 2'd1) begin
						// next step's transition read goes out now
						found_q <= found_new;
						state_q <= mpdfa_pkg::ST_TRN;
					end else if (last_q) begin
						matched_q <= !nc_zero && found_new;
						cur_q     <= '0;
						found_q   <= 1'b0;
						state_q   <= mpdfa_pkg::ST_OUT;
					end else begin
						found_q <= found_new;
						state_q <= mpdfa_pkg::ST_IDLE;
					end
				end
				mpdfa_pkg::ST_OUT: begin
					if (!out_stall) begin
						state_q <= mpdfa_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mpdfa_pkg::ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// no new beat while a result is held
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while result pending");

	// a transition read is only in flight with steps queued
	a_trn_has_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpdfa_pkg::ST_TRN) |-> (step_cnt_q != 2'd0))
		else $error("transition read with empty step queue");

	// at most two bytes pending
	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q != 2'd3)
		else $error("pending count out of range");

	// message state is back at the root once a result is out
	a_out_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cur_q == '0 && !found_q && pend_cnt_q == mpdfa_pkg::PEND_NONE))
		else $error("message state not cleared at result");

	// result beat returns to idle
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> (state_q == mpdfa_pkg::ST_IDLE))
		else $error("no return to idle after result");
`endif

endmodule

`default_nettype wire
